// ----- rtl/lmph_pkg.sv -----
// lmph_pkg: shared types and constants for the level meter peak hold block
// configuration register indexes, reset values and the configuration struct
// no dependencies
package lmph_pkg;

    localparam int COEF_BITS  = 16;
    localparam int HOLD_BITS  = 8;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_STEREO_MODE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ATTACK_COEF        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DECAY_COEF         = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD_TICKS         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PEAK_DECAY_COEF    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVITY_THRESHOLD = 3'd5;

    localparam logic [COEF_BITS-1:0] RST_ATTACK_COEF        = 16'd52429;
    localparam logic [COEF_BITS-1:0] RST_DECAY_COEF         = 16'd3277;
    localparam logic [HOLD_BITS-1:0] RST_HOLD_TICKS         = 8'd120;
    localparam logic [COEF_BITS-1:0] RST_PEAK_DECAY_COEF    = 16'd62259;
    localparam logic [COEF_BITS-1:0] RST_ACTIVITY_THRESHOLD = 16'd66;

    typedef struct packed {
        logic                 stereo_mode;
        logic [COEF_BITS-1:0] attack_coef;
        logic [COEF_BITS-1:0] decay_coef;
        logic [HOLD_BITS-1:0] hold_ticks;
        logic [COEF_BITS-1:0] peak_decay_coef;
        logic [COEF_BITS-1:0] activity_threshold;
    } lmph_cfg_t;

endpackage

// ----- rtl/level_meter_peak_hold.sv -----
// level_meter_peak_hold: top level of the two channel peak hold level meter
// depends on lmph_pkg, lmph_cfg and lmph_chan
//
// Each accepted transaction is one meter tick and yields one result. A tick goes
// through an input register and an update step into the result register, so
// ticks are taken one per clock unless a result waits for m_ready. The rate is
// set by the channel state loop: the level multiply, the peak compare and the
// hold counter close as one combinational path. While a result waits for
// m_ready, one more tick can be held in the input register.
module level_meter_peak_hold import lmph_pkg::*; #(
    parameter int LEVEL_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [LEVEL_BITS-1:0] s_target_left,
    input  logic [LEVEL_BITS-1:0] s_target_right,
    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [LEVEL_BITS-1:0] m_level_left,
    output logic [LEVEL_BITS-1:0] m_level_right,
    output logic [LEVEL_BITS-1:0] m_peak_left,
    output logic [LEVEL_BITS-1:0] m_peak_right,
    output logic                  m_active
);

    lmph_cfg_t cfg;

    logic                  in_valid_reg;
    logic [LEVEL_BITS-1:0] tgt_left_reg;
    logic [LEVEL_BITS-1:0] tgt_right_reg;
    logic                  m_valid_reg;
    logic [LEVEL_BITS-1:0] m_level_left_reg;
    logic [LEVEL_BITS-1:0] m_level_right_reg;
    logic [LEVEL_BITS-1:0] m_peak_left_reg;
    logic [LEVEL_BITS-1:0] m_peak_right_reg;
    logic                  m_active_reg;

    logic                  advance;
    logic                  s_accept;
    logic [LEVEL_BITS-1:0] lvl_l;
    logic [LEVEL_BITS-1:0] lvl_r;
    logic [LEVEL_BITS-1:0] pk_l;
    logic [LEVEL_BITS-1:0] pk_r;
    logic                  act_l;
    logic                  act_r;

    assign advance  = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready  = !in_valid_reg || advance;
    assign s_accept = s_valid && s_ready;

    lmph_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    lmph_chan #(.LEVEL_BITS(LEVEL_BITS)) u_chan_left (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .tick_en    (advance),
        .target     (tgt_left_reg),
        .cfg        (cfg),
        .level_next (lvl_l),
        .peak_next  (pk_l),
        .act        (act_l)
    );

    lmph_chan #(.LEVEL_BITS(LEVEL_BITS)) u_chan_right (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .tick_en    (advance && cfg.stereo_mode),
        .target     (tgt_right_reg),
        .cfg        (cfg),
        .level_next (lvl_r),
        .peak_next  (pk_r),
        .act        (act_r)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            tgt_left_reg  <= s_target_left;
            tgt_right_reg <= s_target_right;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_level_left_reg  <= lvl_l;
            m_peak_left_reg   <= pk_l;
            m_level_right_reg <= cfg.stereo_mode ? lvl_r : '0;
            m_peak_right_reg  <= cfg.stereo_mode ? pk_r : '0;
            m_active_reg      <= act_l || (cfg.stereo_mode && act_r);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_level_left  = m_level_left_reg;
    assign m_level_right = m_level_right_reg;
    assign m_peak_left   = m_peak_left_reg;
    assign m_peak_right  = m_peak_right_reg;
    assign m_active      = m_active_reg;

`ifndef ASSERT_OFF
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> (!in_valid_reg && !m_valid_reg))
        else $error("pipeline valid not cleared by reset");

    a_advance_fills_out: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_valid_reg)
        else $error("tick advanced without a result");

    a_stall_holds_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=>
            (in_valid_reg && $stable(tgt_left_reg) && $stable(tgt_right_reg)))
        else $error("stalled tick lost or changed");

    a_mono_right_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !cfg.stereo_mode) |=>
            (m_level_right_reg == '0 && m_peak_right_reg == '0))
        else $error("right channel result not zero in mono mode");
`endif

endmodule

// ----- rtl/lmph_cfg.sv -----
// lmph_cfg: configuration register file of the level meter
// depends on lmph_pkg
module lmph_cfg import lmph_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output lmph_cfg_t             cfg
);

    lmph_cfg_t cfg_reg;
    lmph_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_STEREO_MODE:        cfg_next.stereo_mode        = cfg_wdata[0];
                REG_ATTACK_COEF:        cfg_next.attack_coef        = cfg_wdata[COEF_BITS-1:0];
                REG_DECAY_COEF:         cfg_next.decay_coef         = cfg_wdata[COEF_BITS-1:0];
                REG_HOLD_TICKS:         cfg_next.hold_ticks         = cfg_wdata[HOLD_BITS-1:0];
                REG_PEAK_DECAY_COEF:    cfg_next.peak_decay_coef    = cfg_wdata[COEF_BITS-1:0];
                REG_ACTIVITY_THRESHOLD: cfg_next.activity_threshold = cfg_wdata[COEF_BITS-1:0];
                default:                cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.stereo_mode        <= 1'b0;
            cfg_reg.attack_coef        <= RST_ATTACK_COEF;
            cfg_reg.decay_coef         <= RST_DECAY_COEF;
            cfg_reg.hold_ticks         <= RST_HOLD_TICKS;
            cfg_reg.peak_decay_coef    <= RST_PEAK_DECAY_COEF;
            cfg_reg.activity_threshold <= RST_ACTIVITY_THRESHOLD;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- rtl/lmph_chan.sv -----
// lmph_chan: one meter channel, level, peak and hold state with the tick update
// depends on lmph_pkg
module lmph_chan import lmph_pkg::*; #(
    parameter int LEVEL_BITS = 16
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  tick_en,
    input  logic [LEVEL_BITS-1:0] target,
    input  lmph_cfg_t             cfg,
    output logic [LEVEL_BITS-1:0] level_next,
    output logic [LEVEL_BITS-1:0] peak_next,
    output logic                  act
);

    localparam int PW = LEVEL_BITS + COEF_BITS;
    localparam int CW = (LEVEL_BITS > COEF_BITS) ? LEVEL_BITS : COEF_BITS;

    logic [LEVEL_BITS-1:0] cur_reg;
    logic [LEVEL_BITS-1:0] pk_reg;
    logic [HOLD_BITS-1:0]  hold_reg;
    logic [HOLD_BITS-1:0]  hold_next;

    logic                  rise;
    logic [LEVEL_BITS-1:0] diff;
    logic [COEF_BITS-1:0]  coef;
    logic [PW-1:0]         prod;
    logic [PW-1:0]         prod_ceil;
    logic [PW-1:0]         pk_prod;
    logic [LEVEL_BITS-1:0] gap;

    always_comb begin
        rise      = target > cur_reg;
        diff      = rise ? (target - cur_reg) : (cur_reg - target);
        coef      = rise ? cfg.attack_coef : cfg.decay_coef;
        prod      = PW'(diff) * PW'(coef);
        prod_ceil = prod + PW'({COEF_BITS{1'b1}});
        // falling step rounds toward minus infinity
        level_next = rise ? (cur_reg + prod[PW-1:COEF_BITS])
                          : (cur_reg - prod_ceil[PW-1:COEF_BITS]);
        pk_prod   = PW'(pk_reg) * PW'(cfg.peak_decay_coef);
        if (level_next > pk_reg) begin
            peak_next = level_next;
            hold_next = cfg.hold_ticks;
        end else if (hold_reg != '0) begin
            peak_next = pk_reg;
            hold_next = hold_reg - 1'b1;
        end else begin
            peak_next = pk_prod[PW-1:COEF_BITS];
            hold_next = hold_reg;
        end
        gap = (level_next > target) ? (level_next - target) : (target - level_next);
        act = (CW'(gap) > CW'(cfg.activity_threshold)) ||
              (CW'(peak_next) > CW'(cfg.activity_threshold));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_reg  <= '0;
            pk_reg   <= '0;
            hold_reg <= '0;
        end else if (tick_en) begin
            cur_reg  <= level_next;
            pk_reg   <= peak_next;
            hold_reg <= hold_next;
        end
    end

endmodule

// ----- verif/tb_level_meter_peak_hold.sv -----
// tb_level_meter_peak_hold: self-checking testbench for the peak hold level meter
// random valid/ready gaps on both channels, config phases, in-bench ballistics predictor
// depends on lmph_pkg and rtl/level_meter_peak_hold.sv
`timescale 1ns / 1ps

module tb_level_meter_peak_hold;
    import lmph_pkg::*;

    localparam int LB          = 16;
    localparam int STALL_LIMIT = 2000;
    localparam int MAX_GAP     = 18;
    localparam int N_PHASES    = 12;
    localparam int PHASE_TICKS = 127;

    // indexes past the register list, the block must ignore them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef struct packed {
        logic [LB-1:0] target_left;
        logic [LB-1:0] target_right;
    } meter_tick_t;

    typedef struct packed {
        logic [LB-1:0] level_left;
        logic [LB-1:0] level_right;
        logic [LB-1:0] peak_left;
        logic [LB-1:0] peak_right;
        logic          active;
    } meter_reading_t;

    typedef struct packed {
        logic [LB-1:0]        lvl;
        logic [LB-1:0]        pk;
        logic [HOLD_BITS-1:0] hold;
    } meter_chan_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    logic [LB-1:0]         s_target_left = '0;
    logic [LB-1:0]         s_target_right = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [LB-1:0]         m_level_left;
    logic [LB-1:0]         m_level_right;
    logic [LB-1:0]         m_peak_left;
    logic [LB-1:0]         m_peak_right;
    logic                  m_active;

    level_meter_peak_hold #(.LEVEL_BITS(LB)) uut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_target_left  (s_target_left),
        .s_target_right (s_target_right),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_level_left   (m_level_left),
        .m_level_right  (m_level_right),
        .m_peak_left    (m_peak_left),
        .m_peak_right   (m_peak_right),
        .m_active       (m_active)
    );

    meter_tick_t    ticks_q[$];
    meter_reading_t readings_q[$];

    lmph_cfg_t      meter_cfg;
    meter_chan_t    chan_left;
    meter_chan_t    chan_right;

    logic           s_fire = 1'b0;
    logic           m_fire = 1'b0;
    int             send_wait = 0;
    int             send_calm = 0;
    int             rcv_wait = 0;
    int             rcv_calm = 0;
    int             err_count = 0;
    int             idle_cycles = 0;

    meter_reading_t want;
    meter_reading_t got;
    logic           act_left;
    logic           act_right;
    meter_tick_t    next_tick;

    initial begin
        forever #5 aclk = ~aclk;
    end

    // one ballistics tick of one channel
    function automatic meter_chan_t meter_step(input meter_chan_t st, input logic [LB-1:0] tgt,
                                               output logic act);
        meter_chan_t            nx;
        logic [LB-1:0]          diff;
        logic [LB+COEF_BITS:0]  prod;
        logic [LB:0]            fall;
        logic [LB-1:0]          gap;
        nx = st;
        if (tgt > st.lvl) begin
            diff = tgt - st.lvl;
            prod = diff * meter_cfg.attack_coef;
            nx.lvl = st.lvl + prod[LB+COEF_BITS-1:COEF_BITS];
        end else begin
            diff = st.lvl - tgt;
            prod = diff * meter_cfg.decay_coef + {COEF_BITS{1'b1}};
            fall = prod[LB+COEF_BITS:COEF_BITS];
            nx.lvl = st.lvl - fall[LB-1:0];
        end
        if (nx.lvl > st.pk) begin
            nx.pk = nx.lvl;
            nx.hold = meter_cfg.hold_ticks;
        end else if (st.hold != '0) begin
            nx.hold = st.hold - 1'b1;
        end else begin
            prod = st.pk * meter_cfg.peak_decay_coef;
            nx.pk = prod[LB+COEF_BITS-1:COEF_BITS];
        end
        gap = (nx.lvl > tgt) ? nx.lvl - tgt : tgt - nx.lvl;
        act = (gap > meter_cfg.activity_threshold) || (nx.pk > meter_cfg.activity_threshold);
        return nx;
    endfunction

    function automatic logic [COEF_BITS-1:0] pick_coef(input logic [COEF_BITS-1:0] dflt);
        case ($urandom_range(0, 4))
            0: return '0;
            1: return '1;
            2: return dflt;
            3: return COEF_BITS'($urandom_range(0, 300));
            default: return COEF_BITS'($urandom);
        endcase
    endfunction

    task automatic add_tick(input logic [LB-1:0] tl, input logic [LB-1:0] tr);
        meter_tick_t t;
        t.target_left = tl;
        t.target_right = tr;
        ticks_q = {ticks_q, t};
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic drain;
        while (!(ticks_q.size() == 0 && !s_valid && readings_q.size() == 0))
            @(posedge aclk);
    endtask

    // predictor and result checker, sampled at the rising edge
    always @(posedge aclk) begin
        s_fire = aresetn && s_valid && s_ready;
        m_fire = aresetn && m_valid && m_ready;
        if (!aresetn) begin
            meter_cfg.stereo_mode = 1'b0;
            meter_cfg.attack_coef = RST_ATTACK_COEF;
            meter_cfg.decay_coef = RST_DECAY_COEF;
            meter_cfg.hold_ticks = RST_HOLD_TICKS;
            meter_cfg.peak_decay_coef = RST_PEAK_DECAY_COEF;
            meter_cfg.activity_threshold = RST_ACTIVITY_THRESHOLD;
            chan_left = '0;
            chan_right = '0;
        end else begin
            if (m_fire) begin
                got.level_left = m_level_left;
                got.level_right = m_level_right;
                got.peak_left = m_peak_left;
                got.peak_right = m_peak_right;
                got.active = m_active;
                if (readings_q.size() == 0) begin
                    err_count++;
                    if (err_count <= 10)
                        $display("unexpected transaction: lvl %0d/%0d pk %0d/%0d act %0d",
                                 got.level_left, got.level_right, got.peak_left,
                                 got.peak_right, got.active);
                end else begin
                    want = readings_q.pop_front();
                    if (got.level_left !== want.level_left
                        || got.level_right !== want.level_right
                        || got.peak_left !== want.peak_left
                        || got.peak_right !== want.peak_right
                        || got.active !== want.active) begin
                        err_count++;
                        if (err_count <= 10)
                            $display(
                                "mismatch: exp %0d %0d %0d %0d %0d, got %0d %0d %0d %0d %0d",
                                want.level_left, want.level_right, want.peak_left,
                                want.peak_right, want.active, got.level_left,
                                got.level_right, got.peak_left, got.peak_right,
                                got.active);
                    end
                end
            end
            if (s_fire) begin
                chan_left = meter_step(chan_left, s_target_left, act_left);
                want.level_left = chan_left.lvl;
                want.peak_left = chan_left.pk;
                if (meter_cfg.stereo_mode) begin
                    chan_right = meter_step(chan_right, s_target_right, act_right);
                    want.level_right = chan_right.lvl;
                    want.peak_right = chan_right.pk;
                end else begin
                    act_right = 1'b0;
                    want.level_right = '0;
                    want.peak_right = '0;
                end
                want.active = act_left | act_right;
                readings_q = {readings_q, want};
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_STEREO_MODE:        meter_cfg.stereo_mode = cfg_wdata[0];
                    REG_ATTACK_COEF:        meter_cfg.attack_coef = cfg_wdata;
                    REG_DECAY_COEF:         meter_cfg.decay_coef = cfg_wdata;
                    REG_HOLD_TICKS:         meter_cfg.hold_ticks = cfg_wdata[HOLD_BITS-1:0];
                    REG_PEAK_DECAY_COEF:    meter_cfg.peak_decay_coef = cfg_wdata;
                    REG_ACTIVITY_THRESHOLD: meter_cfg.activity_threshold = cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // tick driver
    always @(negedge aclk) begin
        if (aresetn && (!s_valid || s_fire)) begin
            if (send_wait > 0) begin
                send_wait--;
                s_valid <= 1'b0;
            end else if (ticks_q.size() > 0) begin
                next_tick = ticks_q.pop_front();
                s_target_left <= next_tick.target_left;
                s_target_right <= next_tick.target_right;
                s_valid <= 1'b1;
                if (send_calm > 0) begin
                    send_calm--;
                    send_wait = 0;
                end else begin
                    send_wait = $urandom_range(0, MAX_GAP);
                    if ($urandom_range(0, 39) == 0)
                        send_calm = $urandom_range(20, 80);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // reading sink with random backpressure
    always @(negedge aclk) begin
        if (m_fire) begin
            if (rcv_calm > 0) begin
                rcv_calm--;
                rcv_wait = 0;
            end else begin
                rcv_wait = $urandom_range(0, MAX_GAP);
                if ($urandom_range(0, 39) == 0)
                    rcv_calm = $urandom_range(20, 80);
            end
        end
        if (rcv_wait > 0) begin
            rcv_wait--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_valid && s_ready) || (m_valid && m_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("tb_level_meter_peak_hold: errors");
                $finish;
            end
        end
    end

    initial begin
        int            pat;
        int            seg_len;
        int            n;
        logic [LB-1:0] c1;
        logic [LB-1:0] c2;
        logic [LB-1:0] tl;
        logic [LB-1:0] tr;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // mono at reset values, right targets must not matter
        add_tick('1, '1);
        add_tick('1, '0);
        add_tick('1, '1);
        add_tick('0, '1);
        add_tick('0, '0);
        add_tick(16'd1, '1);
        drain();

        // stereo, zero hold, full decay so a falling level lands on the target
        set_reg(REG_STEREO_MODE, 16'd1);
        set_reg(REG_HOLD_TICKS, 16'd0);
        set_reg(REG_DECAY_COEF, 16'hFFFF);
        set_reg(REG_SPARE_LO, 16'hFFFF);
        set_reg(REG_SPARE_HI, 16'h0000);
        add_tick('1, '0);
        add_tick('0, '1);
        add_tick('0, '0);
        add_tick('0, '0);
        add_tick(16'd40000, 16'd40000);
        add_tick(16'd40000, 16'd40000);
        drain();

        // frozen levels, peak collapses at once
        set_reg(REG_ATTACK_COEF, 16'd0);
        set_reg(REG_DECAY_COEF, 16'd0);
        set_reg(REG_PEAK_DECAY_COEF, 16'd0);
        set_reg(REG_ACTIVITY_THRESHOLD, 16'd0);
        add_tick('1, '1);
        add_tick(16'd12345, 16'd54321);
        add_tick('0, '0);
        drain();

        // back to mono, right state must carry over
        set_reg(REG_ATTACK_COEF, 16'hFFFF);
        set_reg(REG_DECAY_COEF, RST_DECAY_COEF);
        set_reg(REG_HOLD_TICKS, 16'hFFFF);
        set_reg(REG_PEAK_DECAY_COEF, 16'hFFFF);
        set_reg(REG_ACTIVITY_THRESHOLD, 16'hFFFF);
        set_reg(REG_STEREO_MODE, 16'd0);
        add_tick('1, 16'd3);
        add_tick(16'd1000, 16'd2);
        add_tick('0, 16'd1);
        drain();
        set_reg(REG_STEREO_MODE, 16'hFFFF);
        add_tick(16'd2, '1);
        add_tick('0, '0);
        add_tick('1, '1);
        add_tick('0, '0);
        drain();

        for (int ph = 0; ph < N_PHASES; ph++) begin
            set_reg(REG_STEREO_MODE, (ph % 3 == 2) ? 16'($urandom) & 16'hFFFE : 16'($urandom));
            set_reg(REG_ATTACK_COEF, pick_coef(RST_ATTACK_COEF));
            set_reg(REG_DECAY_COEF, pick_coef(RST_DECAY_COEF));
            case ($urandom_range(0, 4))
                0: set_reg(REG_HOLD_TICKS, 16'd0);
                1: set_reg(REG_HOLD_TICKS, 16'd255);
                2: set_reg(REG_HOLD_TICKS, 16'($urandom_range(1, 8)) | 16'(($urandom & 8'hFF) << 8));
                3: set_reg(REG_HOLD_TICKS, 16'(RST_HOLD_TICKS));
                default: set_reg(REG_HOLD_TICKS, 16'($urandom));
            endcase
            set_reg(REG_PEAK_DECAY_COEF, pick_coef(RST_PEAK_DECAY_COEF));
            set_reg(REG_ACTIVITY_THRESHOLD, pick_coef(RST_ACTIVITY_THRESHOLD));
            if ($urandom_range(0, 2) == 0)
                set_reg(CFG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)), 16'($urandom));

            n = 0;
            while (n < PHASE_TICKS) begin
                seg_len = $urandom_range(1, 40);
                pat = $urandom_range(0, 4);
                c1 = LB'($urandom);
                c2 = LB'($urandom);
                for (int k = 0; k < seg_len && n < PHASE_TICKS; k++) begin
                    case (pat)
                        0: begin
                            tl = LB'($urandom);
                            tr = LB'($urandom);
                        end
                        1: begin
                            tl = c1;
                            tr = c2;
                        end
                        2: begin
                            // burst then quiet, lets the hold run out
                            tl = (k == 0) ? (c1 | 16'h8000) : 16'($urandom_range(0, 40));
                            tr = (k == 0) ? (c2 | 16'h8000) : 16'($urandom_range(0, 40));
                        end
                        3: begin
                            tl = $urandom_range(0, 1) ? '1 : '0;
                            tr = $urandom_range(0, 1) ? '1 : '0;
                        end
                        default: begin
                            tl = LB'($urandom_range(0, 200));
                            tr = LB'($urandom_range(0, 200));
                        end
                    endcase
                    add_tick(tl, tr);
                    n++;
                end
                // sender holds off until every reading is back
                if ($urandom_range(0, 5) == 0)
                    drain();
            end
            drain();
        end

        repeat (10) @(posedge aclk);
        if (err_count == 0 && readings_q.size() == 0) begin
            $display("tb_level_meter_peak_hold: clean");
        end else begin
            $display("tb_level_meter_peak_hold: errors");
        end
        $finish;
    end

endmodule
